// ----- rtl/rsid_pkg.sv -----
// Shared types, constants and helpers for the run-length scanline image decoder.
// Used by rsid_front, rsid_queue, rsid_back and rle_scanline_image_decoder_unit.
package rsid_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COMPRESSED_MODE = 2'd0;
	localparam logic [1:0] CFG_BYTES_PER_LINE  = 2'd1;
	localparam logic [1:0] CFG_LINES_PER_IMAGE = 2'd2;

	// Register reset values.
	localparam logic       COMPRESSED_MODE_RST = 1'b1;
	localparam logic [6:0] BYTES_PER_LINE_RST  = 7'd70;
	localparam logic [7:0] LINES_PER_IMAGE_RST = 8'd192;

	// Result kinds.
	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_HDR_OK  = 2'd1;
	localparam logic [1:0] KIND_HDR_BAD = 2'd2;

	// Header bytes.
	localparam logic [7:0] HDR_X     = 8'h58;
	localparam logic [7:0] HDR_C     = 8'h43;
	localparam logic [7:0] HDR_R     = 8'h52;
	localparam logic [7:0] HDR_BYTE3 = 8'd140;
	localparam logic [7:0] HDR_BYTE4 = 8'd192;
	localparam logic [2:0] HDR_LAST_INDEX = 3'd4;

	// Run marker: top two bits set, count in the low six bits.
	localparam logic [1:0] RUN_MARK = 2'b11;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		CMD_PIXELS,
		CMD_HDR_OK,
		CMD_HDR_BAD
	} cmd_kind_t;

	// One queued command: all results caused by one input word.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] value;
		logic [5:0] count;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pixel_value;
		logic [6:0] column;
		logic [7:0] row;
		logic       line_end;
		logic       line_uniform;
		logic [7:0] line_color;
		logic       image_end;
		logic       last_of_item;
	} result_t;

	// Expected header byte at a given header position.
	function automatic logic [7:0] header_byte(input logic [2:0] idx, input logic mode);
		logic [7:0] want;
		case (idx)
			3'd0: want = HDR_X;
			3'd1: want = mode ? HDR_C : HDR_R;
			3'd2: want = HDR_C;
			3'd3: want = HDR_BYTE3;
			default: want = HDR_BYTE4;
		endcase
		return want;
	endfunction

endpackage

// ----- rtl/rsid_front.sv -----
// Front end: takes input words, checks the header and classifies data bytes
// into queued commands. Depends on rsid_pkg.
module rsid_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [7:0]     data_byte,
	input  logic           first_of_file,
	input  logic           compressed_mode,
	output logic           push,
	output rsid_pkg::cmd_t push_cmd
);
	import rsid_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_REJECT
	} phase_t;

	phase_t     phase_q, phase_d, phase_e;
	logic [2:0] hdr_idx_q, hdr_idx_d, hdr_idx_e;
	logic       hdr_ok_q, hdr_ok_d, hdr_ok_e;
	logic       run_pend_q, run_pend_d, run_pend_e;
	logic [5:0] run_len_q, run_len_d, run_len_e;
	logic       ok_n;

	always_comb begin
		// A restart brings the decoder back to the start of a header.
		phase_e    = first_of_file ? PH_HEADER : phase_q;
		hdr_idx_e  = first_of_file ? 3'd0 : hdr_idx_q;
		hdr_ok_e   = first_of_file ? 1'b1 : hdr_ok_q;
		run_pend_e = first_of_file ? 1'b0 : run_pend_q;
		run_len_e  = first_of_file ? 6'd0 : run_len_q;

		phase_d    = phase_e;
		hdr_idx_d  = hdr_idx_e;
		hdr_ok_d   = hdr_ok_e;
		run_pend_d = run_pend_e;
		run_len_d  = run_len_e;
		push       = 1'b0;
		push_cmd   = '{kind: CMD_PIXELS, value: data_byte, count: 6'd1};
		ok_n       = hdr_ok_e & (data_byte == header_byte(hdr_idx_e, compressed_mode));

		case (phase_e)
			PH_HEADER: begin
				hdr_ok_d = ok_n;
				if (hdr_idx_e >= HDR_LAST_INDEX) begin
					push          = in_fire;
					push_cmd.kind = ok_n ? CMD_HDR_OK : CMD_HDR_BAD;
					hdr_idx_d     = 3'd0;
					phase_d       = ok_n ? PH_DATA : PH_REJECT;
					run_pend_d    = 1'b0;
					run_len_d     = 6'd0;
				end else begin
					hdr_idx_d = hdr_idx_e + 3'd1;
				end
			end
			PH_DATA: begin
				if (!compressed_mode) begin
					run_pend_d = 1'b0;
					run_len_d  = 6'd0;
					push       = in_fire;
				end else if (run_pend_e) begin
					run_pend_d     = 1'b0;
					run_len_d      = 6'd0;
					push_cmd.count = run_len_e;
					// A run with a zero count swallows its value byte.
					push           = in_fire && (run_len_e != 6'd0);
				end else if (data_byte[7:6] == RUN_MARK) begin
					run_pend_d = 1'b1;
					run_len_d  = data_byte[5:0];
				end else begin
					push = in_fire;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_idx_q  <= 3'd0;
			hdr_ok_q   <= 1'b1;
			run_pend_q <= 1'b0;
			run_len_q  <= 6'd0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			hdr_idx_q  <= hdr_idx_d;
			hdr_ok_q   <= hdr_ok_d;
			run_pend_q <= run_pend_d;
			run_len_q  <= run_len_d;
		end
	end

endmodule

// ----- rtl/rsid_queue.sv -----
// Short command queue between the front end and the pixel back end.
// Depends on rsid_pkg for the command type.
module rsid_queue #(
	parameter int DEPTH = rsid_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsid_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output rsid_pkg::cmd_t head_cmd
);
	import rsid_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/rsid_back.sv -----
// Back end: expands queued commands into result words, tracking column, row,
// line uniformity and image end, and holds the output register. Depends on rsid_pkg.
module rsid_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [6:0]        bytes_per_line,
	input  logic [7:0]        lines_per_image,
	input  logic              head_valid,
	input  rsid_pkg::cmd_t    head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output rsid_pkg::result_t out_result
);
	import rsid_pkg::*;

	logic       cmd_active_q;
	cmd_t       cmd_q;
	logic [5:0] rem_q;
	logic [6:0] column_q;
	logic [7:0] row_q;
	logic [7:0] first_color_q;
	logic       all_same_q;
	logic       done_q;
	logic       out_valid_q;
	result_t    out_q;

	logic       out_free, is_pix, step, finish, load;
	logic       le, ie, same, last_pix;
	logic [7:0] fc;
	result_t    res_d;

	assign out_free = !out_valid_q || out_ready;
	assign is_pix   = (cmd_q.kind == CMD_PIXELS);
	// Pixel commands after the image end are dropped without waiting on the output.
	assign step     = cmd_active_q && (out_free || (is_pix && done_q));

	always_comb begin
		fc       = (column_q == 7'd0) ? cmd_q.value : first_color_q;
		same     = (column_q == 7'd0) ? 1'b1 : (all_same_q && (cmd_q.value == first_color_q));
		le       = ({1'b0, column_q} + 8'd1) >= {1'b0, bytes_per_line};
		ie       = le && (({1'b0, row_q} + 9'd1) >= {1'b0, lines_per_image});
		last_pix = (rem_q == 6'd1) || ie;
	end

	// Result word for the current step of the active command.
	always_comb begin
		res_d = '0;
		res_d.last_of_item = 1'b1;
		case (cmd_q.kind)
			CMD_HDR_OK:  res_d.kind = KIND_HDR_OK;
			CMD_HDR_BAD: res_d.kind = KIND_HDR_BAD;
			default: begin
				res_d.kind         = KIND_PIXEL;
				res_d.pixel_value  = cmd_q.value;
				res_d.column       = column_q;
				res_d.row          = row_q;
				res_d.line_end     = le;
				res_d.line_uniform = le && same;
				res_d.line_color   = fc;
				res_d.image_end    = ie;
				res_d.last_of_item = last_pix;
			end
		endcase
	end

	assign finish    = step && (!is_pix || done_q || last_pix);
	assign load      = (!cmd_active_q || finish) && head_valid;
	assign pop       = load;
	assign out_valid = out_valid_q;
	assign out_result = out_q;

	always_ff @(posedge clk) begin
		if (step && !(is_pix && done_q)) begin
			out_q <= res_d;
		end
		if (load) begin
			cmd_q <= head_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_active_q  <= 1'b0;
			rem_q         <= 6'd0;
			column_q      <= 7'd0;
			row_q         <= 8'd0;
			first_color_q <= 8'd0;
			all_same_q    <= 1'b1;
			done_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				cmd_active_q <= 1'b1;
				rem_q        <= head_cmd.count;
			end else if (finish) begin
				cmd_active_q <= 1'b0;
			end

			if (step && !(is_pix && done_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (step) begin
				case (cmd_q.kind)
					CMD_HDR_OK: begin
						column_q      <= 7'd0;
						row_q         <= 8'd0;
						first_color_q <= 8'd0;
						all_same_q    <= 1'b1;
						done_q        <= 1'b0;
					end
					CMD_HDR_BAD: begin
						done_q <= 1'b1;
					end
					default: begin
						if (!done_q) begin
							first_color_q <= fc;
							all_same_q    <= same;
							if (le) begin
								column_q <= 7'd0;
								row_q    <= row_q + 8'd1;
							end else begin
								column_q <= column_q + 7'd1;
							end
							if (ie) begin
								done_q <= 1'b1;
							end
							if (!load) begin
								rem_q <= rem_q - 6'd1;
							end
						end
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/rle_scanline_image_decoder_unit.sv -----
// Top level of the run-length scanline image decoder: configuration registers,
// stream ports and the front end, command queue and back end. Depends on rsid_pkg.
//
// The block takes an image file one byte per word on the slave stream. The first
// five bytes form a header ('X', then 'C' in run-length mode or 'R' in raw mode,
// then 'C', 140 and 192); the fifth byte yields one result word that accepts or
// rejects it. After a good header, data bytes become pixel words carrying their
// column and row, a line-end mark with the line's uniformity and first color,
// and an image-end mark on the final pixel; later bytes yield nothing until a
// word with the restart flag set. In run-length mode a byte with both top bits
// set gives a repeat count (low six bits) for the following byte. An input word
// is accepted whenever the command queue (four entries by default) has room. The
// back end produces one result word per cycle while the output is taken; a
// literal or raw byte yields one pixel word and a run as many as its count. The
// output register and queue let the input keep flowing while results wait to be
// taken. Configuration should be written only while the block is idle.
module rle_scanline_image_decoder_unit #(
	parameter int QUEUE_DEPTH = rsid_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,   // [0] first_of_file
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] pixel_value, [14:8] column, [22:15] row,
	                                    // [23] line_end, [24] line_uniform,
	                                    // [32:25] line_color, [33] image_end, rest zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,   // last_of_item
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import rsid_pkg::*;

	logic       compressed_mode_q;
	logic [6:0] bytes_per_line_q;
	logic [7:0] lines_per_image_q;

	logic    in_fire, push, full, pop, head_valid;
	cmd_t    push_cmd, head_cmd;
	result_t result;

	// Registers are always writable; writes to unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_mode_q <= COMPRESSED_MODE_RST;
			bytes_per_line_q  <= BYTES_PER_LINE_RST;
			lines_per_image_q <= LINES_PER_IMAGE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COMPRESSED_MODE: compressed_mode_q <= cfg_data[0];
				CFG_BYTES_PER_LINE:  bytes_per_line_q  <= cfg_data[6:0];
				CFG_LINES_PER_IMAGE: lines_per_image_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A word is taken whenever the queue can hold the command it might produce.
	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	rsid_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.data_byte       (s_axis_tdata),
		.first_of_file   (s_axis_tuser[0]),
		.compressed_mode (compressed_mode_q),
		.push            (push),
		.push_cmd        (push_cmd)
	);

	rsid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	rsid_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.bytes_per_line  (bytes_per_line_q),
		.lines_per_image (lines_per_image_q),
		.head_valid      (head_valid),
		.head_cmd        (head_cmd),
		.pop             (pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_result      (result)
	);

	assign m_axis_tdata = {6'd0, result.image_end, result.line_color, result.line_uniform,
		result.line_end, result.row, result.column, result.pixel_value};
	assign m_axis_tuser = result.kind;
	assign m_axis_tlast = result.last_of_item;

endmodule
